FILE: rtl/deq_pkg.sv
package deq_pkg;

   // Payload field widths of the two channels
   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   // Operation codes carried in func
   localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd1;
   localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 2'd2;
   localparam logic [FUNC_W-1:0] OP_POP_BACK   = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // take the request item and update the ring
      logic load;     // move the finished result into the output register
   } cmd_type;

endpackage

FILE: rtl/deq_req_if.sv
interface deq_req_if;
   logic                               valid;
   logic                               ready;
   logic [deq_pkg::FUNC_W-1:0]         func;
   logic signed [deq_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

FILE: rtl/deq_rsp_if.sv
interface deq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [deq_pkg::VALUE_W-1:0] pop_value;
   logic [deq_pkg::STATUS_W-1:0]       status;
   logic [deq_pkg::OCC_W-1:0]          occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);
endinterface

FILE: rtl/deq_ctrl.sv
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;   // waiting for a request item
   localparam logic ST_EXEC = 1'b1;   // store read returning, result pending

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cmd.accept = req_valid && req_ready;
   assign cmd.load   = (state_ff == ST_EXEC) && out_free;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/deq_datapath.sv
module deq_datapath #(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  deq_pkg::cmd_type                    cmd,
   input  logic [deq_pkg::FUNC_W-1:0]          func,
   input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
   output logic signed [deq_pkg::VALUE_W-1:0]  pop_value,
   output logic [deq_pkg::STATUS_W-1:0]        status,
   output logic [deq_pkg::OCC_W-1:0]           occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_prev, head_next, tail_prev, tail_next;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             wr_en, rd_en;
   logic             is_full, is_empty;
   logic [deq_pkg::STATUS_W-1:0] status_in, pend_status_ff;
   logic             pop_ok_in, pend_pop_ok_ff;
   logic [DATA_WIDTH-1:0] word;

   logic signed [deq_pkg::VALUE_W-1:0] pop_value_ff;
   logic [deq_pkg::STATUS_W-1:0]       status_ff;
   logic [deq_pkg::OCC_W-1:0]          occupancy_ff;

   assign word      = DATA_WIDTH'($unsigned(push_value));
   assign is_full   = (count_ff == FULL_CNT);
   assign is_empty  = (count_ff == '0);
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      status_in = deq_pkg::ST_OK;
      pop_ok_in = 1'b0;
      case (func)
         deq_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               head_in  = head_prev;
               wr_addr  = head_prev;
               wr_en    = cmd.accept;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               tail_in  = tail_next;
               wr_addr  = tail_ff;
               wr_en    = cmd.accept;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               head_in   = head_next;
               rd_addr   = head_ff;
               rd_en     = cmd.accept;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (is_empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               tail_in   = tail_prev;
               rd_addr   = tail_prev;
               rd_en     = cmd.accept;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         default: status_in = deq_pkg::ST_OK;
      endcase
   end

   // Ring store: at most one write or one registered read per item
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= word;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff <= status_in;
         pend_pop_ok_ff <= pop_ok_in;
      end
      if (cmd.load) begin
         pop_value_ff <= pend_pop_ok_ff ? deq_pkg::VALUE_W'($unsigned(rd_data_ff)) : '0;
         status_ff    <= pend_status_ff;
         occupancy_ff <= deq_pkg::OCC_W'(count_ff);
      end
   end

   assign pop_value = pop_value_ff;
   assign status    = status_ff;
   assign occupancy = occupancy_ff;

endmodule

FILE: rtl/circular_deque.sv
// An accepted item's result reaches the output register after the index update and,
// for a pop, the registered read of the ring store; it waits in the controller's
// execute state while that register holds a result the sink has not yet taken.
// A new item is taken only once the result of the previous one has been loaded.
// Reset (synchronous, active high) empties the deque and clears both handshakes;
// the ring store itself is not cleared and needs no clearing pass.
module circular_deque #(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);

   // The controller decides when an item is taken and when its result moves to
   // the output register; the datapath owns the head and tail indices, the
   // word count, the ring store and the output register.
   deq_pkg::cmd_type cmd;

   // A new item is taken only while the controller is idle. The output
   // register parts the two sides, so an item may be accepted while the
   // previous result still waits for the sink; its result then waits in the
   // controller's execute state until the output register is free.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // A push to a full deque and a pop from an empty one leave the indices and
   // count as they were and report full or empty with a zero pop value. The
   // occupancy shown is the count after the operation, in its low four bits.
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .func       (req_ch.func),
      .push_value (req_ch.push_value),
      .pop_value  (rsp_ch.pop_value),
      .status     (rsp_ch.status),
      .occupancy  (rsp_ch.occupancy)
   );

endmodule

FILE: rtl/deq_checker.sv
module deq_checker #(
   parameter int DEPTH = 8
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [deq_pkg::VALUE_W-1:0] pop_value,
   input logic [deq_pkg::STATUS_W-1:0]       status,
   input logic [deq_pkg::OCC_W-1:0]          occupancy
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_value) && $stable(status)
         && $stable(occupancy))
      else $error("result changed while stalled");

   // One item at a time: no acceptance in the cycle after one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in the cycle after an accept");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != deq_pkg::ST_OK |-> pop_value == '0)
      else $error("refused operation returned a value");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == deq_pkg::ST_EMPTY |-> occupancy == '0)
      else $error("empty status with nonzero occupancy");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == deq_pkg::ST_FULL |-> occupancy == deq_pkg::OCC_W'(DEPTH))
      else $error("full status with occupancy other than depth");

endmodule

bind circular_deque deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .pop_value (rsp_ch.pop_value),
   .status    (rsp_ch.status),
   .occupancy (rsp_ch.occupancy)
);
